[hw/rtl/lpot_pkg.sv]
// ----------------------------------------------------------------------------
// lpot_pkg: shared types and constants for the lidar offset-time filter
// Holds the payload structs, config register indexes and the CORDIC table.
// ----------------------------------------------------------------------------
package lpot_pkg;

    localparam int RING_COUNT = 32;
    localparam int RING_W = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_USE_POINT_TIME = 2'd0,
        REG_KEEP_EVERY     = 2'd1,
        REG_MIN_RANGE_SQ   = 2'd2,
        REG_US_PER_YAW     = 2'd3
    } cfg_reg_t;

    localparam int YAW_W  = 15;
    localparam int OFF_W  = 20;
    localparam int CRD_W  = 31;   // coords * 256 plus CORDIC growth
    localparam int ANG_W  = 24;   // 1/16384 degree, covers +/- 2 half turns
    localparam int CRD_STEPS = 16;

    localparam logic signed [ANG_W-1:0] HALF_TURN_FINE = 24'sd2949120;
    localparam int FULL_TURN_YAW = 23040;
    localparam int HALF_TURN_YAW = 11520;
    localparam logic [OFF_W-1:0] OFFSET_MAX = 20'hFFFFF;

    typedef struct packed {
        logic               frame_start;
        logic signed [19:0] x_mm;
        logic signed [19:0] y_mm;
        logic signed [19:0] z_mm;
        logic [7:0]         intensity;
        logic [7:0]         ring;
        logic [19:0]        point_time_us;
    } in_item_t;

    typedef struct packed {
        logic signed [19:0] out_x_mm;
        logic signed [19:0] out_y_mm;
        logic signed [19:0] out_z_mm;
        logic [7:0]         out_intensity;
        logic [19:0]        offset_time_us;
    } out_item_t;

    // Work handed from the classify front to the compute back.
    typedef struct packed {
        logic               frame_start;
        logic               in_range;   // ring < RING_COUNT
        logic               keep;       // index phase was zero
        logic [RING_W-1:0]  ring;
        logic signed [19:0] x_mm;
        logic signed [19:0] y_mm;
        logic signed [19:0] z_mm;
        logic [7:0]         intensity;
        logic [19:0]        point_time_us;
    } task_t;

    function automatic logic signed [ANG_W-1:0] cordic_angle(input logic [3:0] i);
        case (i)
            4'd0:  cordic_angle = 24'sd737280;
            4'd1:  cordic_angle = 24'sd435242;
            4'd2:  cordic_angle = 24'sd229970;
            4'd3:  cordic_angle = 24'sd116736;
            4'd4:  cordic_angle = 24'sd58595;
            4'd5:  cordic_angle = 24'sd29326;
            4'd6:  cordic_angle = 24'sd14667;
            4'd7:  cordic_angle = 24'sd7334;
            4'd8:  cordic_angle = 24'sd3667;
            4'd9:  cordic_angle = 24'sd1833;
            4'd10: cordic_angle = 24'sd917;
            4'd11: cordic_angle = 24'sd458;
            4'd12: cordic_angle = 24'sd229;
            4'd13: cordic_angle = 24'sd115;
            4'd14: cordic_angle = 24'sd57;
            4'd15: cordic_angle = 24'sd29;
            default: cordic_angle = '0;
        endcase
    endfunction

endpackage

[hw/rtl/lpot_front.sv]
// ----------------------------------------------------------------------------
// lpot_front: request intake and classification
// Tracks the index phase, checks ring range and pushes a task to the queue.
// ----------------------------------------------------------------------------
module lpot_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lpot_pkg::in_item_t in_data,
    input  logic [7:0]         keep_every,
    output logic               push,
    output lpot_pkg::task_t    push_data,
    input  logic               full
);
    import lpot_pkg::*;

    logic [7:0] phase_reg, phase_next;
    logic [7:0] cur_phase;
    logic [7:0] inc;

    assign in_ready = !full;
    assign push     = in_valid && !full;

    always_comb
    begin
        cur_phase = in_data.frame_start ? 8'd0 : phase_reg;
        inc       = cur_phase + 8'd1;
        phase_next = (inc >= keep_every) ? 8'd0 : inc;
    end

    always_comb
    begin
        push_data.frame_start   = in_data.frame_start;
        push_data.in_range      = ({1'b0, in_data.ring} < 9'(RING_COUNT));
        push_data.keep          = (cur_phase == 8'd0);
        push_data.ring          = in_data.ring[RING_W-1:0];
        push_data.x_mm          = in_data.x_mm;
        push_data.y_mm          = in_data.y_mm;
        push_data.z_mm          = in_data.z_mm;
        push_data.intensity     = in_data.intensity;
        push_data.point_time_us = in_data.point_time_us;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else if (push)
            phase_reg <= phase_next;
    end
endmodule

[hw/rtl/lpot_queue.sv]
// ----------------------------------------------------------------------------
// lpot_queue: two-entry task queue between front and back
// Lets the front keep taking requests while the back is busy.
// ----------------------------------------------------------------------------
module lpot_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lpot_pkg::task_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output lpot_pkg::task_t pop_data
);
    import lpot_pkg::*;

    task_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

[hw/rtl/lpot_back.sv]
// ----------------------------------------------------------------------------
// lpot_back: offset computation and output stage
// Iterative CORDIC yaw, ring state update, range test and offset scaling.
// ----------------------------------------------------------------------------
module lpot_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               task_valid,
    input  lpot_pkg::task_t    task_data,
    output logic               pop,
    input  logic               use_point_time,
    input  logic [39:0]        min_range_sq_mm2,
    input  logic [23:0]        us_per_yaw_unit_q16,
    output logic               out_valid,
    input  logic               out_ready,
    output lpot_pkg::out_item_t out_data
);
    import lpot_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_CALC  = 8'b00000010,
        S_YAW   = 8'b00000100,
        S_RD    = 8'b00001000,
        S_DIF   = 8'b00010000,
        S_MUL   = 8'b00100000,
        S_ADJ   = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    task_t tk_reg;
    logic [RING_COUNT-1:0] seen_reg;

    // ring memories (contents undefined until written)
    logic signed [YAW_W-1:0] first_mem [RING_COUNT];
    logic [OFF_W-1:0]        last_mem  [RING_COUNT];
    logic signed [YAW_W-1:0] first_rd_reg;
    logic [OFF_W-1:0]        last_rd_reg;

    logic signed [CRD_W-1:0] cx_reg, cy_reg;
    logic signed [ANG_W-1:0] cz_reg;
    logic [3:0]              it_reg;
    logic                    origin_reg;
    logic signed [YAW_W-1:0] yaw_reg;

    // range square: one product per cycle, accumulated
    logic [1:0]  sq_cnt_reg;
    logic [41:0] rsq_reg;
    logic        range_ok_reg;

    logic [15:0]      d_reg;
    logic [39:0]      prod_reg;
    logic [39:0]      turn_prod_reg;   // scaled full turn, before the shift
    logic [OFF_W-1:0] off_reg;

    out_item_t out_reg;
    logic      out_valid_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // coordinates scaled by 256, pre-rotated by half a turn for negative x
    logic signed [CRD_W-1:0] lx, ly, ld_x, ld_y;
    logic signed [ANG_W-1:0] ld_z;
    always_comb
    begin
        lx = CRD_W'(task_data.x_mm) <<< 8;
        ly = CRD_W'(task_data.y_mm) <<< 8;
        if (lx < 0)
        begin
            ld_z = (ly >= 0) ? HALF_TURN_FINE : -HALF_TURN_FINE;
            ld_x = -lx;
            ld_y = -ly;
        end
        else
        begin
            ld_z = '0;
            ld_x = lx;
            ld_y = ly;
        end
    end

    // CORDIC step
    logic signed [CRD_W-1:0] dx, dy;
    logic signed [ANG_W-1:0] ang;
    assign dx  = cy_reg >>> it_reg;
    assign dy  = cx_reg >>> it_reg;
    assign ang = cordic_angle(it_reg);

    // yaw round and wrap
    logic signed [ANG_W-1:0] zr;
    logic signed [16:0]      yw;
    always_comb
    begin
        zr = (cz_reg + 24'sd128) >>> 8;
        yw = zr[16:0];
        if (yw > 17'(HALF_TURN_YAW))
            yw = yw - 17'(FULL_TURN_YAW);
        else if (yw <= -17'(HALF_TURN_YAW))
            yw = yw + 17'(FULL_TURN_YAW);
    end

    // squared coordinate for the current step
    logic signed [19:0] sq_src;
    logic signed [39:0] sq_prod;
    always_comb
    begin
        case (sq_cnt_reg)
            2'd0:    sq_src = tk_reg.x_mm;
            2'd1:    sq_src = tk_reg.y_mm;
            default: sq_src = tk_reg.z_mm;
        endcase
        sq_prod = sq_src * sq_src;
    end

    logic signed [16:0] dsum;
    always_comb
    begin
        dsum = 17'(first_rd_reg) - 17'(yaw_reg);
        if (yaw_reg > first_rd_reg)
            dsum = dsum + 17'(FULL_TURN_YAW);
    end

    logic out_free;
    assign out_free = !out_valid_reg || out_ready;

    logic [23:0]      off_scaled;
    logic [23:0]      turn_scaled;
    logic [24:0]      off_adj;
    logic [OFF_W-1:0] off_sat;
    assign off_scaled  = prod_reg[39:16];
    assign turn_scaled = turn_prod_reg[39:16];
    always_comb
    begin
        off_adj = {1'b0, off_scaled};
        if (off_scaled < {4'b0, last_rd_reg})
            off_adj = off_adj + {1'b0, turn_scaled};
        off_sat = (off_adj > {5'b0, OFFSET_MAX}) ? OFFSET_MAX : off_adj[OFF_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        pop = 1'b0;
        case (state_reg)
            S_IDLE:
                if (task_valid)
                begin
                    pop = 1'b1;
                    state_next = S_CALC;
                end
            S_CALC:
                if (!tk_reg.in_range)
                    state_next = S_IDLE;
                else if (use_point_time)
                begin
                    if (sq_cnt_reg == 2'd3)
                        state_next = S_OUT;
                end
                else if (it_reg == 4'd15)
                    state_next = S_YAW;
            S_YAW:   state_next = S_RD;
            S_RD:    state_next = seen_reg[tk_reg.ring] ? S_DIF : S_IDLE;
            S_DIF:   state_next = S_MUL;
            S_MUL:   state_next = S_ADJ;
            S_ADJ:   state_next = S_OUT;
            S_OUT:
                if (!(tk_reg.keep && range_ok_reg) || out_free)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (task_valid)
                begin
                    tk_reg <= task_data;
                    cx_reg <= ld_x;
                    cy_reg <= ld_y;
                    cz_reg <= ld_z;
                    origin_reg <= (task_data.x_mm == '0) && (task_data.y_mm == '0);
                    it_reg <= 4'd0;
                    sq_cnt_reg <= 2'd0;
                    rsq_reg <= '0;
                    turn_prod_reg <= 40'(us_per_yaw_unit_q16) * 40'd23040 + 40'd32768;
                end
            S_CALC:
            begin
                if (sq_cnt_reg != 2'd3)
                begin
                    rsq_reg <= rsq_reg + {2'b0, sq_prod};
                    sq_cnt_reg <= sq_cnt_reg + 2'd1;
                end
                else
                    range_ok_reg <= (rsq_reg > {2'b0, min_range_sq_mm2});
                if (cy_reg > 0)
                begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    cz_reg <= cz_reg + ang;
                end
                else
                begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    cz_reg <= cz_reg - ang;
                end
                it_reg <= it_reg + 4'd1;
            end
            S_YAW:
                yaw_reg <= origin_reg ? '0 : yw[YAW_W-1:0];
            S_RD:
            begin
                first_rd_reg <= first_mem[tk_reg.ring];
                last_rd_reg  <= last_mem[tk_reg.ring];
                if (!seen_reg[tk_reg.ring])
                begin
                    first_mem[tk_reg.ring] <= yaw_reg;
                    last_mem[tk_reg.ring]  <= '0;
                end
            end
            S_DIF:
                d_reg <= 16'(dsum);
            S_MUL:
                prod_reg <= 40'(d_reg) * 40'(us_per_yaw_unit_q16) + 40'd32768;
            S_ADJ:
            begin
                last_mem[tk_reg.ring] <= off_sat;
                off_reg <= off_sat;
            end
            S_OUT:
                if (tk_reg.keep && range_ok_reg && out_free)
                begin
                    out_reg.out_x_mm       <= tk_reg.x_mm;
                    out_reg.out_y_mm       <= tk_reg.y_mm;
                    out_reg.out_z_mm       <= tk_reg.z_mm;
                    out_reg.out_intensity  <= tk_reg.intensity;
                    out_reg.offset_time_us <= use_point_time ? tk_reg.point_time_us
                                                             : off_reg;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // frame start clears the seen bits in both modes
            if (state_reg == S_CALC && tk_reg.frame_start)
                seen_reg <= '0;
            else if (state_reg == S_RD)
                seen_reg[tk_reg.ring] <= 1'b1;
            if (state_reg == S_OUT && tk_reg.keep && range_ok_reg && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end
endmodule

[hw/rtl/lidar_point_offset_time_filter.sv]
// ----------------------------------------------------------------------------
// lidar_point_offset_time_filter: top level
// Front classifies points, a queue decouples, back computes offset time.
//
//   channel  dir  handshake           payload
//   in       in   in_valid/in_ready   lpot_pkg::in_item_t
//   out      out  out_valid/out_ready lpot_pkg::out_item_t
//   cfg      in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// The back works on one point at a time. Yaw mode: take, 16 CORDIC steps,
// round, ring read, difference, multiply, adjust, output; the first point
// of a ring leaves after the ring read. Point-time mode: take, 4 range-square
// steps, output. Out-of-range ring points leave at the first calculate step.
// The front takes a request in any cycle the two-entry queue is not full;
// a result held in the output register stalls the back in its output step.
// Reset clears config to defaults, ring seen bits and the index phase.
// ----------------------------------------------------------------------------
module lidar_point_offset_time_filter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lpot_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output lpot_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [39:0]         cfg_data
);
    import lpot_pkg::*;

    logic        use_pt_reg;
    logic [7:0]  keep_reg;
    logic [39:0] min_rsq_reg;
    logic [23:0] us_yaw_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_pt_reg  <= 1'b0;
            keep_reg    <= 8'd3;
            min_rsq_reg <= 40'd16000000;
            us_yaw_reg  <= 24'd283660;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_USE_POINT_TIME: use_pt_reg  <= cfg_data[0];
                REG_KEEP_EVERY:     keep_reg    <= cfg_data[7:0];
                REG_MIN_RANGE_SQ:   min_rsq_reg <= cfg_data;
                REG_US_PER_YAW:     us_yaw_reg  <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    logic  push, full, pop, not_empty;
    task_t push_data, pop_data;

    lpot_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .keep_every(keep_reg),
        .push(push), .push_data(push_data), .full(full)
    );

    lpot_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(push), .push_data(push_data), .full(full),
        .pop(pop), .not_empty(not_empty), .pop_data(pop_data)
    );

    lpot_back u_back (
        .clk(clk), .rst_n(rst_n),
        .task_valid(not_empty), .task_data(pop_data), .pop(pop),
        .use_point_time(use_pt_reg),
        .min_range_sq_mm2(min_rsq_reg),
        .us_per_yaw_unit_q16(us_yaw_reg),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );
endmodule

[hw/rtl/lpot_checker.sv]
// ----------------------------------------------------------------------------
// lpot_port_checks: port-level checks on the top level
// Output handshake hold, config ready and reset behavior.
// ----------------------------------------------------------------------------
module lpot_port_checks (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input lpot_pkg::out_item_t out_data,
    input logic                cfg_ready
);
    import lpot_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port not ready");

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result shown during reset");
endmodule

bind lidar_point_offset_time_filter lpot_port_checks u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .cfg_ready(cfg_ready)
);
